// ===== hw/rtl/wsse_pkg.sv =====
// Shared types and constants for the wall sensor steering error unit.
// Used by the lanes, the merge stage and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package wsse_pkg;

    localparam int unsigned ADC_W    = 12;
    localparam int unsigned LEVEL_W  = 13;
    localparam int unsigned OFFSET_W = 14;
    localparam int unsigned ERROR_W  = 15;
    localparam int unsigned CASE_W   = 3;

    // Steering case codes, in priority order.
    localparam logic [CASE_W-1:0] CASE_TOO_CLOSE = 3'd0;
    localparam logic [CASE_W-1:0] CASE_FRONT     = 3'd1;
    localparam logic [CASE_W-1:0] CASE_BOTH      = 3'd2;
    localparam logic [CASE_W-1:0] CASE_RIGHT     = 3'd3;
    localparam logic [CASE_W-1:0] CASE_LEFT      = 3'd4;
    localparam logic [CASE_W-1:0] CASE_NONE      = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] REG_RF_PARAMS = 3'd0;
    localparam logic [2:0] REG_LF_PARAMS = 3'd1;
    localparam logic [2:0] REG_RS_PARAMS = 3'd2;
    localparam logic [2:0] REG_LS_PARAMS = 3'd3;
    localparam logic [2:0] REG_JUMP      = 3'd4;
    localparam logic [2:0] REG_MARGIN    = 3'd5;

    // Registered findings of one front sensor lane.
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;     // level minus reference, two's complement
        logic                above_stop; // level above no-control threshold
        logic                above_ctrl; // level above control threshold
        logic                above_wall; // level above wall limit
        logic                above_hit;  // level above hit threshold
    } front_lane_t;

    // Registered findings of one side sensor lane.
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;     // level minus reference, two's complement
        logic                steer_wall; // wall test with the jump-switched threshold
        logic                above_wall; // wall test with the plain wall limit
    } side_lane_t;

    // One result beat.
    typedef struct packed {
        logic [ERROR_W-1:0] steer_error;
        logic [CASE_W-1:0]  control_case;
        logic               front_wall;
        logic               right_wall;
        logic               left_wall;
        logic               near_front;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wsse_front_lane.sv =====
// Front sensor lane: level from the dark and lit readings and its threshold tests.
// Depends on wsse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsse_front_lane (
    input  wire logic                        aclk,
    input  wire logic                        advance,
    input  wire logic [wsse_pkg::ADC_W-1:0]  dark,
    input  wire logic [wsse_pkg::ADC_W-1:0]  lit,
    input  wire logic [5*wsse_pkg::ADC_W-1:0] params,
    output wsse_pkg::front_lane_t            lane_out
);

    localparam int unsigned AW = wsse_pkg::ADC_W;
    localparam int unsigned OW = wsse_pkg::OFFSET_W;

    logic signed [OW-1:0] level;
    logic signed [OW-1:0] ref_val, limit, ctrl, stop, hit;
    wsse_pkg::front_lane_t lane_next, lane_reg;

    always_comb begin
        level   = $signed({2'b00, lit}) - $signed({2'b00, dark});
        ref_val = $signed({2'b00, params[0*AW +: AW]});
        limit   = $signed({2'b00, params[1*AW +: AW]});
        ctrl    = $signed({2'b00, params[2*AW +: AW]});
        stop    = $signed({2'b00, params[3*AW +: AW]});
        hit     = $signed({2'b00, params[4*AW +: AW]});

        lane_next.offset     = level - ref_val;
        lane_next.above_stop = level > stop;
        lane_next.above_ctrl = level > ctrl;
        lane_next.above_wall = level > limit;
        lane_next.above_hit  = level > hit;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/wsse_side_lane.sv =====
// Side sensor lane: level, jump detection against the previous level and wall tests.
// Depends on wsse_pkg; holds the previous side level.
`timescale 1ns / 1ps
`default_nettype none

module wsse_side_lane (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         advance,
    input  wire logic [wsse_pkg::ADC_W-1:0]   dark,
    input  wire logic [wsse_pkg::ADC_W-1:0]   lit,
    input  wire logic [2*wsse_pkg::ADC_W-1:0] params,
    input  wire logic [wsse_pkg::ADC_W-1:0]   jump_filter,
    input  wire logic [wsse_pkg::ADC_W-1:0]   ref_margin,
    output wsse_pkg::side_lane_t              lane_out
);

    localparam int unsigned AW = wsse_pkg::ADC_W;
    localparam int unsigned LW = wsse_pkg::LEVEL_W;
    localparam int unsigned OW = wsse_pkg::OFFSET_W;

    logic signed [OW-1:0] level;
    logic signed [OW-1:0] diff;
    logic signed [OW-1:0] filt;
    logic signed [OW-1:0] ref_val, limit, switched, threshold;
    logic                 jump;
    logic [LW-1:0]        prev_reg;
    wsse_pkg::side_lane_t lane_next, lane_reg;

    always_comb begin
        level    = $signed({2'b00, lit}) - $signed({2'b00, dark});
        // The previous level is a 13-bit signed value; the difference fits 14 bits.
        diff     = level - $signed({prev_reg[LW-1], prev_reg});
        filt     = $signed({2'b00, jump_filter});
        jump     = (diff > filt) || (diff < -filt);
        ref_val  = $signed({2'b00, params[0 +: AW]});
        limit    = $signed({2'b00, params[AW +: AW]});
        switched = ref_val + $signed({2'b00, ref_margin});
        threshold = jump ? switched : limit;

        lane_next.offset     = level - ref_val;
        lane_next.steer_wall = level > threshold;
        lane_next.above_wall = level > limit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (advance) begin
            prev_reg <= level[LW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/wsse_merge.sv =====
// Merge stage: combines the four lanes into the steering case, error and wall flags.
// Depends on wsse_pkg; registers the result beat.
`timescale 1ns / 1ps
`default_nettype none

module wsse_merge (
    input  wire logic                  aclk,
    input  wire logic                  advance,
    input  wire wsse_pkg::front_lane_t rf,
    input  wire wsse_pkg::front_lane_t lf,
    input  wire wsse_pkg::side_lane_t  rs,
    input  wire wsse_pkg::side_lane_t  ls,
    output wsse_pkg::result_t          result
);

    localparam int unsigned EW = wsse_pkg::ERROR_W;

    logic [EW-1:0]     rf_off, lf_off, rs_off, ls_off;
    wsse_pkg::result_t result_next, result_reg;

    always_comb begin
        rf_off = {rf.offset[wsse_pkg::OFFSET_W-1], rf.offset};
        lf_off = {lf.offset[wsse_pkg::OFFSET_W-1], lf.offset};
        rs_off = {rs.offset[wsse_pkg::OFFSET_W-1], rs.offset};
        ls_off = {ls.offset[wsse_pkg::OFFSET_W-1], ls.offset};

        result_next.steer_error = '0;
        priority if (rf.above_stop && lf.above_stop) begin
            result_next.control_case = wsse_pkg::CASE_TOO_CLOSE;
        end else if (rf.above_ctrl && lf.above_ctrl) begin
            result_next.control_case = wsse_pkg::CASE_FRONT;
            result_next.steer_error  = lf_off - rf_off;
        end else if (rs.steer_wall && ls.steer_wall) begin
            result_next.control_case = wsse_pkg::CASE_BOTH;
            result_next.steer_error  = rs_off - ls_off;
        end else if (rs.steer_wall) begin
            result_next.control_case = wsse_pkg::CASE_RIGHT;
            result_next.steer_error  = {rs.offset, 1'b0};
        end else if (ls.steer_wall) begin
            result_next.control_case = wsse_pkg::CASE_LEFT;
            result_next.steer_error  = '0 - {ls.offset, 1'b0};
        end else begin
            result_next.control_case = wsse_pkg::CASE_NONE;
        end

        result_next.front_wall = rf.above_wall && lf.above_wall;
        result_next.right_wall = rs.above_wall;
        result_next.left_wall  = ls.above_wall;
        result_next.near_front = rf.above_hit || lf.above_hit;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/wall_sensor_steer_error_unit.sv =====
// Top level of the wall sensor steering error unit: configuration registers,
// pipeline control, four sensor lanes and the merge stage. Depends on wsse_pkg.
//
// Usage. Each beat on the s_ channel carries one sample frame: the dark and lit
// readings of the right front, left front, right side and left side sensors.
// Each beat on the m_ channel carries one result: the signed steering error, the
// steering case and the front, right, left and near-front wall flags.
// Four lanes, one per sensor, work on a frame side by side; the merge stage then
// picks the steering case by priority and forms the error.
// An accepted input beat passes the lane registers and then the merge stage register
// before its result is valid. The unit accepts one frame per clock and delivers
// one result per clock while the receiver keeps m_tready high.
// When the receiver stalls, the result waits in the output register and one more
// frame can still be taken into the lane registers; only then does s_tready fall.
// Reset (aresetn low, synchronous) empties the pipeline, clears the previous side
// levels to zero and clears all configuration registers.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata, one register
// per clock, and must only be changed while the unit holds no frame in flight.
`timescale 1ns / 1ps
`default_nettype none

module wall_sensor_steer_error_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [59:0] cfg_wdata,
    // Input frames.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata, low bit up: rf_dark, rf_lit, lf_dark, lf_lit,
    // rs_dark, rs_lit, ls_dark, ls_lit (12 bits each).
    input  wire logic [95:0] s_tdata,
    // Results.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata, low bit up: steer_error (15, signed), control_case (3),
    // front_wall, right_wall, left_wall, near_front, two zero pad bits.
    output logic [23:0]      m_tdata
);

    localparam int unsigned AW = wsse_pkg::ADC_W;

    // Configuration registers, laid out as written.
    logic [5*AW-1:0] rf_params_reg;
    logic [5*AW-1:0] lf_params_reg;
    logic [2*AW-1:0] rs_params_reg;
    logic [2*AW-1:0] ls_params_reg;
    logic [AW-1:0]   jump_filter_reg;
    logic [AW-1:0]   ref_margin_reg;

    // Pipeline occupancy: lane stage and output stage.
    logic lane_valid_reg;
    logic out_valid_reg;
    logic out_ready;
    logic lane_ready;
    logic lane_advance;
    logic out_advance;

    wsse_pkg::front_lane_t rf_lane, lf_lane;
    wsse_pkg::side_lane_t  rs_lane, ls_lane;
    wsse_pkg::result_t     result;

    // Register writes; indexes past the list fall into the default arm and are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_params_reg   <= '0;
            lf_params_reg   <= '0;
            rs_params_reg   <= '0;
            ls_params_reg   <= '0;
            jump_filter_reg <= '0;
            ref_margin_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                wsse_pkg::REG_RF_PARAMS: rf_params_reg   <= cfg_wdata[5*AW-1:0];
                wsse_pkg::REG_LF_PARAMS: lf_params_reg   <= cfg_wdata[5*AW-1:0];
                wsse_pkg::REG_RS_PARAMS: rs_params_reg   <= cfg_wdata[2*AW-1:0];
                wsse_pkg::REG_LS_PARAMS: ls_params_reg   <= cfg_wdata[2*AW-1:0];
                wsse_pkg::REG_JUMP:      jump_filter_reg <= cfg_wdata[AW-1:0];
                wsse_pkg::REG_MARGIN:    ref_margin_reg  <= cfg_wdata[AW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Each stage moves on when the stage after it has room; the output register
    // parts the two channels so a stalled receiver does not stop the next frame.
    assign out_ready    = !out_valid_reg || m_tready;
    assign lane_ready   = !lane_valid_reg || out_ready;
    assign lane_advance = s_tvalid && lane_ready;
    assign out_advance  = lane_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (lane_ready) begin
                lane_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= lane_valid_reg;
            end
        end
    end

    wsse_front_lane u_rf_lane (
        .aclk     (aclk),
        .advance  (lane_advance),
        .dark     (s_tdata[0*AW +: AW]),
        .lit      (s_tdata[1*AW +: AW]),
        .params   (rf_params_reg),
        .lane_out (rf_lane)
    );

    wsse_front_lane u_lf_lane (
        .aclk     (aclk),
        .advance  (lane_advance),
        .dark     (s_tdata[2*AW +: AW]),
        .lit      (s_tdata[3*AW +: AW]),
        .params   (lf_params_reg),
        .lane_out (lf_lane)
    );

    // The side lanes update their previous level only when a frame is taken.
    wsse_side_lane u_rs_lane (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (lane_advance),
        .dark        (s_tdata[4*AW +: AW]),
        .lit         (s_tdata[5*AW +: AW]),
        .params      (rs_params_reg),
        .jump_filter (jump_filter_reg),
        .ref_margin  (ref_margin_reg),
        .lane_out    (rs_lane)
    );

    wsse_side_lane u_ls_lane (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (lane_advance),
        .dark        (s_tdata[6*AW +: AW]),
        .lit         (s_tdata[7*AW +: AW]),
        .params      (ls_params_reg),
        .jump_filter (jump_filter_reg),
        .ref_margin  (ref_margin_reg),
        .lane_out    (ls_lane)
    );

    wsse_merge u_merge (
        .aclk    (aclk),
        .advance (out_advance),
        .rf      (rf_lane),
        .lf      (lf_lane),
        .rs      (rs_lane),
        .ls      (ls_lane),
        .result  (result)
    );

    assign s_tready = lane_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, result.near_front, result.left_wall, result.right_wall,
                       result.front_wall, result.control_case, result.steer_error};

endmodule

`default_nettype wire

// ===== hw/rtl/wsse_checker.sv =====
// Port-level checker for the wall sensor steering error unit, bound to the top level.
// Depends only on the top level's ports and the case codes in wsse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsse_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    logic [2:0]  chk_case;
    logic [14:0] chk_error;

    assign chk_case  = m_tdata[17:15];
    assign chk_error = m_tdata[14:0];

    // Reset empties the output stage.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid in the cycle after reset");

    // A held result keeps its value until taken.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    // With the output stage empty the unit must take a frame.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output stage");

    // No steering in the too-close and no-wall cases.
    a_zero_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (chk_case == wsse_pkg::CASE_TOO_CLOSE || chk_case == wsse_pkg::CASE_NONE)
        |-> chk_error == '0)
        else $error("non-zero error without control");

    // Single-side cases double an offset, so the error is even.
    a_single_side_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (chk_case == wsse_pkg::CASE_RIGHT || chk_case == wsse_pkg::CASE_LEFT)
        |-> !chk_error[0])
        else $error("odd error in a single-side case");

endmodule

bind wall_sensor_steer_error_unit wsse_checker u_wsse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
